[rtl/fsp_pkg.sv]
// Package for the five-stage pipeline block: opcodes, operation types and field helpers.
// No dependencies.
package fsp_pkg;

  localparam int unsigned MemWords = 16;
  localparam int unsigned RegCount = 8;

  localparam logic [5:0] OpcRtype = 6'd0;
  localparam logic [5:0] OpcLw    = 6'd35;
  localparam logic [5:0] OpcSw    = 6'd43;
  localparam logic [5:0] OpcBne   = 6'd4;
  localparam logic [5:0] OpcHalt  = 6'd63;
  localparam logic [5:0] FnAdd    = 6'd32;
  localparam logic [5:0] FnSub    = 6'd34;

  typedef enum logic [1:0] {
    OP_LOAD_INSTR = 2'd0,
    OP_LOAD_DATA  = 2'd1,
    OP_TICK       = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  function automatic logic [5:0] opc(input logic [31:0] w);
    return w[31:26];
  endfunction

  function automatic logic is_rtype(input logic [31:0] w);
    return (w[31:26] == OpcRtype) && (w != 32'd0);
  endfunction

  function automatic logic writes_reg(input logic [31:0] w);
    return is_rtype(w) || (w[31:26] == OpcLw);
  endfunction

  function automatic logic uses_imm(input logic [31:0] w);
    return !((w[31:26] == OpcRtype) || (w[31:26] == OpcBne) || (w[31:26] == OpcHalt));
  endfunction

endpackage

[rtl/fsp_core.sv]
// Pipeline core: stores, latches, forwarding, predictor and statistics.
// Depends on fsp_pkg.
module fsp_core #(
  parameter int unsigned MEM_WORDS = fsp_pkg::MemWords,
  parameter int unsigned REG_COUNT = fsp_pkg::RegCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  address_i,
  input  logic [31:0] word_i,
  output logic        halted_o,
  output logic [31:0] pc_o,
  output logic [31:0] cycles_o,
  output logic [31:0] stalls_o,
  output logic [31:0] branches_o,
  output logic [31:0] mispredicts_o,
  output logic        wb_valid_o,
  output logic [2:0]  wb_reg_o,
  output logic [31:0] wb_value_o
);
  import fsp_pkg::*;

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [31:0] imem_q [MEM_WORDS];
  logic [31:0] dmem_q [MEM_WORDS];
  logic [31:0] rf_q   [REG_COUNT];
  logic [1:0]  pred_q [MEM_WORDS];

  logic [31:0] pc_q, cyc_q, stl_q, br_q, mis_q;
  logic [31:0] fd_instr_q, fd_npc_q;
  logic [31:0] de_instr_q, de_npc_q, de_rsv_q, de_rtv_q, de_imm_q, de_tgt_q;
  logic [RW-1:0] de_rs_q, de_rt_q, de_rd_q;
  logic [31:0] em_instr_q, em_alu_q, em_sv_q;
  logic [RW-1:0] em_dest_q;
  logic [31:0] mw_instr_q, mw_mem_q, mw_alu_q;
  logic [RW-1:0] mw_dest_q;

  // Register index from the low bits of the field; the register count is a power of two.
  function automatic logic [RW-1:0] rmod(input logic [4:0] f);
    return f[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] amod(input logic [31:0] a);
    return a[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] pidx(input logic [31:0] npc);
    logic [AW-1:0] t;
    t = npc[AW+1:2];
    return t - AW'(1);
  endfunction

  logic tick, halted, stall, pred_tk, mis, taken, em_ok, mw_ok, fd_nz, de_halt;
  logic [31:0] mwv, a, b, bsel, alu, wbv, npc, nfd_instr, nde_instr, imm, tgt;
  logic [RW-1:0] rs, rt, rd, dest;
  logic [AW-1:0] bidx;
  logic [1:0] c, cn;
  logic [31:0] rsv, rtv;
  logic wb_en;

  assign halted = (opc(mw_instr_q) == OpcHalt);
  assign tick   = en_i && (op_e'(operation_i) == OP_TICK) && !halted;
  assign mwv    = (opc(mw_instr_q) == OpcLw) ? mw_mem_q : mw_alu_q;
  assign wb_en  = (mw_dest_q != '0) && writes_reg(mw_instr_q);

  always_comb begin
    rs  = rmod(fd_instr_q[25:21]);
    rt  = rmod(fd_instr_q[20:16]);
    rd  = rmod(fd_instr_q[15:11]);
    imm = {{16{fd_instr_q[15]}}, fd_instr_q[15:0]};
    tgt = fd_npc_q + (imm << 2);
    // Writeback comes before decode reads the file.
    rsv = (wb_en && mw_dest_q == rs) ? mwv : rf_q[rs];
    rtv = (wb_en && mw_dest_q == rt) ? mwv : rf_q[rt];
    stall = (opc(de_instr_q) == OpcLw) && (de_rt_q == rs || de_rt_q == rt);
    pred_tk = !stall && (opc(fd_instr_q) == OpcBne) && pred_q[pidx(fd_npc_q)][1];
    npc = pc_q + 32'd4;
    nfd_instr = imem_q[amod(pc_q >> 2)];
    nde_instr = fd_instr_q;
    if (stall) begin
      nde_instr = 32'd0;
      nfd_instr = fd_instr_q;
      npc = pc_q;
    end else if (pred_tk) begin
      npc = tgt;
      nfd_instr = 32'd0;
    end
    em_ok = (em_dest_q != '0) && writes_reg(em_instr_q);
    mw_ok = wb_en;
    a = de_rsv_q;
    b = de_rtv_q;
    if (em_ok && em_dest_q == de_rs_q) a = em_alu_q;
    else if (mw_ok && mw_dest_q == de_rs_q) a = mwv;
    if (em_ok && em_dest_q == de_rt_q) b = em_alu_q;
    else if (mw_ok && mw_dest_q == de_rt_q) b = mwv;
    bsel = uses_imm(de_instr_q) ? de_imm_q : b;
    if (opc(de_instr_q) == OpcHalt) alu = 32'd0;
    else if ((opc(de_instr_q) == OpcRtype && de_instr_q[5:0] == FnSub) ||
             opc(de_instr_q) == OpcBne) alu = a - bsel;
    else alu = a + bsel;
    dest = is_rtype(de_instr_q) ? de_rd_q : de_rt_q;
    bidx = pidx(de_npc_q);
    c = pred_q[bidx];
    taken = (a != bsel);
    cn = c;
    if (taken && c != 2'd3) cn = c + 2'd1;
    if (!taken && c != 2'd0) cn = c - 2'd1;
    mis = (opc(de_instr_q) == OpcBne) && (c[1] != taken);
    fd_nz = (nfd_instr != 32'd0) || (opc(nde_instr) == OpcHalt);
    de_halt = (nde_instr != 32'd0);
    if (mis) npc = taken ? de_tgt_q : de_npc_q;
    wbv = mwv;
  end

  logic [31:0] stl_inc;
  assign stl_inc = 32'((stall || pred_tk) ? 1 : 0) + 32'((mis && fd_nz) ? 1 : 0)
                 + 32'((mis && de_halt) ? 1 : 0);

  // All stores reset to zero and the predictor counters to weakly not taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_WORDS; i++) begin
        imem_q[i] <= '0;
        dmem_q[i] <= '0;
        pred_q[i] <= 2'd1;
      end
      for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
      pc_q <= '0; cyc_q <= '0; stl_q <= '0; br_q <= '0; mis_q <= '0;
      fd_instr_q <= '0; fd_npc_q <= '0;
      de_instr_q <= '0; de_npc_q <= '0; de_rsv_q <= '0; de_rtv_q <= '0;
      de_imm_q <= '0; de_tgt_q <= '0; de_rs_q <= '0; de_rt_q <= '0; de_rd_q <= '0;
      em_instr_q <= '0; em_alu_q <= '0; em_sv_q <= '0; em_dest_q <= '0;
      mw_instr_q <= '0; mw_mem_q <= '0; mw_alu_q <= '0; mw_dest_q <= '0;
      wb_valid_o <= 1'b0; wb_reg_o <= '0; wb_value_o <= '0;
    end else if (en_i) begin
      wb_valid_o <= 1'b0; wb_reg_o <= '0; wb_value_o <= '0;
      if (op_e'(operation_i) == OP_LOAD_INSTR) imem_q[amod({28'd0, address_i})] <= word_i;
      if (op_e'(operation_i) == OP_LOAD_DATA)  dmem_q[amod({28'd0, address_i})] <= word_i;
      if (tick) begin
        cyc_q <= cyc_q + 32'd1;
        stl_q <= stl_q + stl_inc;
        if (opc(de_instr_q) == OpcBne) begin
          pred_q[bidx] <= cn;
          br_q <= br_q + 32'd1;
        end
        if (mis) mis_q <= mis_q + 32'd1;
        if (wb_en) begin
          rf_q[mw_dest_q] <= wbv;
          wb_valid_o <= 1'b1;
          wb_reg_o   <= 3'(mw_dest_q);
          wb_value_o <= wbv;
        end
        pc_q <= npc;
        fd_instr_q <= mis ? 32'd0 : nfd_instr;
        fd_npc_q   <= stall ? fd_npc_q : pc_q + 32'd4;
        de_instr_q <= mis ? 32'd0 : nde_instr;
        de_npc_q <= fd_npc_q; de_rs_q <= rs; de_rt_q <= rt; de_rd_q <= rd;
        de_rsv_q <= rsv; de_rtv_q <= rtv; de_imm_q <= imm; de_tgt_q <= tgt;
        em_instr_q <= de_instr_q; em_alu_q <= alu; em_sv_q <= b; em_dest_q <= dest;
        if (opc(em_instr_q) == OpcSw) dmem_q[amod(em_alu_q >> 2)] <= em_sv_q;
        else if (opc(em_instr_q) == OpcLw) mw_mem_q <= dmem_q[amod(em_alu_q >> 2)];
        mw_instr_q <= em_instr_q; mw_alu_q <= em_alu_q; mw_dest_q <= em_dest_q;
      end
    end
  end

  assign halted_o = halted;
  assign pc_o = pc_q;
  assign cycles_o = cyc_q;
  assign stalls_o = stl_q;
  assign branches_o = br_q;
  assign mispredicts_o = mis_q;
endmodule

[rtl/five_stage_pipeline_with_predictor.sv]
// Top level: handshake and result holding around the pipeline core.
// One item accepted every cycle while the result is taken or no result is held.
// Each tick item advances all five stages at once in fsp_core.
// Reset clears all stores, latches, counters; predictor counters reset to weakly not taken.
// Depends on fsp_pkg and fsp_core.
module five_stage_pipeline_with_predictor #(
  parameter int unsigned MEM_WORDS = fsp_pkg::MemWords,
  parameter int unsigned REG_COUNT = fsp_pkg::RegCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  address_i,
  input  logic [31:0] word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        halted_o,
  output logic [31:0] program_counter_o,
  output logic [31:0] cycle_count_o,
  output logic [31:0] stall_count_o,
  output logic [31:0] branch_count_o,
  output logic [31:0] mispredict_count_o,
  output logic        writeback_valid_o,
  output logic [2:0]  writeback_register_o,
  output logic signed [31:0] writeback_value_o
);
  import fsp_pkg::*;

  logic valid_q, acc;
  logic [31:0] wbv;
  assign in_ready_o = !valid_q || out_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (acc) valid_q <= 1'b1;
    else if (out_ready_i) valid_q <= 1'b0;
  end

  fsp_core #(.MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)) u_core (
    .clk_i, .rst_ni, .en_i(acc),
    .operation_i, .address_i, .word_i,
    .halted_o, .pc_o(program_counter_o), .cycles_o(cycle_count_o),
    .stalls_o(stall_count_o), .branches_o(branch_count_o),
    .mispredicts_o(mispredict_count_o),
    .wb_valid_o(writeback_valid_o), .wb_reg_o(writeback_register_o), .wb_value_o(wbv)
  );
  assign writeback_value_o = wbv;
  assign out_valid_o = valid_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(program_counter_o)) else $error("result changed");
  a_wbz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !writeback_valid_o |-> writeback_register_o == 3'd0) else $error("stray writeback");
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_o |=> halted_o) else $error("halt released");
`endif
endmodule
